FILE: hw/rtl/soc_pkg.sv
`timescale 1ns / 1ps

package soc_pkg;

	// Field widths
	localparam int COORD_W   = 32;
	localparam int LEN_W     = 31;
	localparam int QF_W      = 16;
	localparam int UNIT_FRAC = 14;
	localparam int ROT_W     = 20;
	localparam int NRM_ONE   = 1 << UNIT_FRAC;
	localparam int RND       = 1 << (UNIT_FRAC - 1);
	localparam int NORMAL_MIN_DIST = 7;

	// Iterative units
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 15;
	localparam int MID_DEPTH  = 4;

	// Stream layout
	localparam int IN_TDATA_W  = 384;
	localparam int OUT_TDATA_W = 176;
	localparam int SPH_LSB  = 0;
	localparam int RAD_LSB  = 96;
	localparam int BOX_LSB  = 127;
	localparam int SIZE_LSB = 223;
	localparam int ORI_LSB  = 316;

	// Rotation matrix, row major, signed Q5.14 entries
	typedef logic [2:0][2:0][ROT_W-1:0] soc_rot_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic                          miss;
		logic [63:0]                   sumsq;
		logic [LEN_W-1:0]              radius;
		logic [2:0][COORD_W-1:0]       del;
		soc_rot_t                      rot;
		logic [2:0][COORD_W-1:0]       contact;
	} soc_mid_t;

	// Finished result
	typedef struct packed {
		logic                          hit;
		logic [LEN_W-1:0]              penetration;
		logic [2:0][QF_W-1:0]          normal;
		logic [2:0][COORD_W-1:0]       contact;
	} soc_res_t;

endpackage

FILE: hw/rtl/soc_fifo.sv
`timescale 1ns / 1ps

module soc_fifo import soc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  soc_mid_t push_item,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output soc_mid_t head
);

	localparam int PTR_W = $clog2(MID_DEPTH);

	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	soc_mid_t         mem_q [MID_DEPTH];

	assign full  = (cnt_q == (PTR_W + 1)'(MID_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

FILE: hw/rtl/soc_front.sv
`timescale 1ns / 1ps

module soc_front import soc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [IN_TDATA_W-1:0] in_data,
	output logic                  mid_push,
	output soc_mid_t              mid_item,
	input  logic                  mid_full
);

	typedef struct packed {
		logic [LEN_W-1:0]          radius;
		logic [2:0][LEN_W-2:0]     half;
		logic [2:0][COORD_W-1:0]   box;
	} carry_t;

	localparam logic signed [35:0] ONE36 = 36'sd1 <<< (2 * UNIT_FRAC);
	localparam logic signed [39:0] CMAX  = 40'sd2147483647;
	localparam logic signed [39:0] CMIN  = -40'sd2147483648;

	function automatic logic signed [35:0] e36(input logic signed [31:0] a);
		return {{4{a[31]}}, a};
	endfunction

	logic       en;
	logic [8:0] v_q;

	assign en       = !v_q[8] || !mid_full;
	assign in_ready = en;
	assign mid_push = v_q[8] && !mid_full;

	// Valid bits, one per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[7:0], in_valid};
	end

	// s1: unpack, center offset
	logic [COORD_W-1:0] sph [3];
	logic [COORD_W-1:0] bxi [3];
	logic [LEN_W-1:0]   siz [3];
	logic signed [32:0] d_s1 [3];
	logic signed [15:0] qw_s1, qx_s1, qy_s1, qz_s1;
	carry_t             c_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sph[i] = in_data[SPH_LSB + COORD_W*i +: COORD_W];
			bxi[i] = in_data[BOX_LSB + COORD_W*i +: COORD_W];
			siz[i] = in_data[SIZE_LSB + LEN_W*i +: LEN_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]        <= $signed({sph[i][31], sph[i]}) - $signed({bxi[i][31], bxi[i]});
				c_s1.half[i]   <= siz[i][LEN_W-1:1];
				c_s1.box[i]    <= bxi[i];
			end
			c_s1.radius <= in_data[RAD_LSB +: LEN_W];
			qw_s1 <= in_data[ORI_LSB + 3*QF_W +: QF_W];
			qx_s1 <= in_data[ORI_LSB + 2*QF_W +: QF_W];
			qy_s1 <= in_data[ORI_LSB + QF_W +: QF_W];
			qz_s1 <= in_data[ORI_LSB +: QF_W];
		end
	end

	// s2: quaternion products
	logic signed [31:0] pxx_s2, pyy_s2, pzz_s2, pxy_s2, pxz_s2, pyz_s2, pwx_s2, pwy_s2, pwz_s2;
	logic signed [32:0] d_s2 [3];
	carry_t             c_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s2 <= qx_s1 * qx_s1;
			pyy_s2 <= qy_s1 * qy_s1;
			pzz_s2 <= qz_s1 * qz_s1;
			pxy_s2 <= qx_s1 * qy_s1;
			pxz_s2 <= qx_s1 * qz_s1;
			pyz_s2 <= qy_s1 * qz_s1;
			pwx_s2 <= qw_s1 * qx_s1;
			pwy_s2 <= qw_s1 * qy_s1;
			pwz_s2 <= qw_s1 * qz_s1;
			d_s2   <= d_s1;
			c_s2   <= c_s1;
		end
	end

	// s3: rotation matrix, rounded to Q5.14
	logic signed [35:0] rr [3][3];
	logic [35:0]        rsum [3][3];
	soc_rot_t           r_s3;
	logic signed [32:0] d_s3 [3];
	carry_t             c_s3;

	always_comb begin
		rr[0][0] = ONE36 - ((e36(pyy_s2) + e36(pzz_s2)) <<< 1);
		rr[0][1] = (e36(pxy_s2) - e36(pwz_s2)) <<< 1;
		rr[0][2] = (e36(pxz_s2) + e36(pwy_s2)) <<< 1;
		rr[1][0] = (e36(pxy_s2) + e36(pwz_s2)) <<< 1;
		rr[1][1] = ONE36 - ((e36(pxx_s2) + e36(pzz_s2)) <<< 1);
		rr[1][2] = (e36(pyz_s2) - e36(pwx_s2)) <<< 1;
		rr[2][0] = (e36(pxz_s2) - e36(pwy_s2)) <<< 1;
		rr[2][1] = (e36(pyz_s2) + e36(pwx_s2)) <<< 1;
		rr[2][2] = ONE36 - ((e36(pxx_s2) + e36(pyy_s2)) <<< 1);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rsum[i][j] = rr[i][j] + 36'(RND);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_s3[i][j] <= rsum[i][j][UNIT_FRAC +: ROT_W];
				end
			end
			d_s3 <= d_s2;
			c_s3 <= c_s2;
		end
	end

	// s4: products of R transposed and offset
	logic signed [52:0] pl_s4 [3][3];
	soc_rot_t           r_s4;
	carry_t             c_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pl_s4[i][j] <= $signed(r_s3[j][i]) * d_s3[j];
				end
			end
			r_s4 <= r_s3;
			c_s4 <= c_s3;
		end
	end

	// s5: local coordinates
	logic [54:0]        lsum [3];
	logic signed [40:0] loc_s5 [3];
	soc_rot_t           r_s5;
	carry_t             c_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lsum[i] = {{2{pl_s4[i][0][52]}}, pl_s4[i][0]} + {{2{pl_s4[i][1][52]}}, pl_s4[i][1]}
				+ {{2{pl_s4[i][2][52]}}, pl_s4[i][2]} + 55'(RND);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) loc_s5[i] <= lsum[i][54:UNIT_FRAC];
			r_s5 <= r_s4;
			c_s5 <= c_s4;
		end
	end

	// s6: clamp to half extents, offset from closest point
	logic signed [40:0] hs [3];
	logic signed [40:0] hn [3];
	logic signed [40:0] cl [3];
	logic [41:0]        dl [3];
	logic signed [30:0] clp_s6 [3];
	logic signed [41:0] del_s6 [3];
	soc_rot_t           r_s6;
	carry_t             c_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hs[i] = $signed({11'b0, c_s5.half[i]});
			hn[i] = -hs[i];
			if (loc_s5[i] > hs[i])      cl[i] = hs[i];
			else if (loc_s5[i] < hn[i]) cl[i] = hn[i];
			else                        cl[i] = loc_s5[i];
			dl[i] = {loc_s5[i][40], loc_s5[i]} - {cl[i][40], cl[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				clp_s6[i] <= cl[i][30:0];
				del_s6[i] <= dl[i];
			end
			r_s6 <= r_s5;
			c_s6 <= c_s5;
		end
	end

	// s7: far test, squares, contact products
	logic signed [42:0] rs43;
	logic signed [42:0] dp43 [3];
	logic               far;
	logic               far_s7;
	logic [63:0]        sq_s7 [3];
	logic [61:0]        rr_s7;
	logic signed [50:0] pc_s7 [3][3];
	logic [31:0]        del_s7 [3];
	soc_rot_t           r_s7;
	carry_t             c_s7;

	always_comb begin
		rs43 = $signed({12'b0, c_s6.radius});
		far  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dp43[i] = $signed({del_s6[i][41], del_s6[i]});
			if (dp43[i] >= rs43 || -dp43[i] >= rs43) far = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			far_s7 <= far;
			rr_s7  <= c_s6.radius * c_s6.radius;
			for (int i = 0; i < 3; i++) begin
				sq_s7[i]  <= $signed(del_s6[i][31:0]) * $signed(del_s6[i][31:0]);
				del_s7[i] <= del_s6[i][31:0];
				for (int j = 0; j < 3; j++) begin
					pc_s7[i][j] <= $signed(r_s6[i][j]) * clp_s6[j];
				end
			end
			r_s7 <= r_s6;
			c_s7 <= c_s6;
		end
	end

	// s8: squared distance test, world contact before saturation
	logic [63:0]        ssum;
	logic [52:0]        acs [3];
	logic [38:0]        acr [3];
	logic               miss_s8;
	logic [63:0]        sumsq_s8;
	logic signed [39:0] cw_s8 [3];
	logic [31:0]        del_s8 [3];
	logic [LEN_W-1:0]   rad_s8;
	soc_rot_t           r_s8;

	always_comb begin
		ssum = {2'b0, sq_s7[0][61:0]} + {2'b0, sq_s7[1][61:0]} + {2'b0, sq_s7[2][61:0]};
		for (int i = 0; i < 3; i++) begin
			acs[i] = {{2{pc_s7[i][0][50]}}, pc_s7[i][0]} + {{2{pc_s7[i][1][50]}}, pc_s7[i][1]}
				+ {{2{pc_s7[i][2][50]}}, pc_s7[i][2]} + 53'(RND);
			acr[i] = acs[i][52:UNIT_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			miss_s8  <= far_s7 || (ssum >= {2'b0, rr_s7});
			sumsq_s8 <= ssum;
			for (int i = 0; i < 3; i++) begin
				cw_s8[i] <= {{8{c_s7.box[i][31]}}, c_s7.box[i]} + {acr[i][38], acr[i]};
			end
			del_s8 <= del_s7;
			rad_s8 <= c_s7.radius;
			r_s8   <= r_s7;
		end
	end

	// s9: saturate contact, hand the item to the queue
	soc_mid_t item_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s9.miss   <= miss_s8;
			item_s9.sumsq  <= sumsq_s8;
			item_s9.radius <= rad_s8;
			item_s9.rot    <= r_s8;
			for (int i = 0; i < 3; i++) begin
				item_s9.del[i] <= del_s8[i];
				if (cw_s8[i] > CMAX)      item_s9.contact[i] <= CMAX[31:0];
				else if (cw_s8[i] < CMIN) item_s9.contact[i] <= CMIN[31:0];
				else                      item_s9.contact[i] <= cw_s8[i][31:0];
			end
		end
	end

	assign mid_item = item_s9;

endmodule

FILE: hw/rtl/soc_back.sv
`timescale 1ns / 1ps

module soc_back import soc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     mid_valid,
	input  soc_mid_t mid_item,
	output logic     mid_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output soc_res_t out_res
);

	typedef struct packed {
		logic                    miss;
		logic [LEN_W-1:0]        radius;
		logic [2:0][COORD_W-1:0] del;
		soc_rot_t                rot;
		logic [2:0][COORD_W-1:0] contact;
	} bcar_t;

	localparam logic signed [23:0] NMAX = 24'(NRM_ONE);
	localparam logic signed [23:0] NMIN = -24'(NRM_ONE);

	logic     en;
	logic     ov_q;
	soc_res_t res_q;

	assign en        = !ov_q || out_ready;
	assign mid_pop   = mid_valid && en;
	assign out_valid = ov_q;
	assign out_res   = res_q;

	// Square root, one result bit per stage
	logic [SQRT_STEPS-1:0] sq_v;
	logic [63:0]           sq_x    [SQRT_STEPS];
	logic [33:0]           sq_rem  [SQRT_STEPS];
	logic [31:0]           sq_root [SQRT_STEPS];
	bcar_t                 sq_c    [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
		logic        v_i;
		logic [63:0] x_i;
		logic [33:0] rem_i;
		logic [31:0] root_i;
		bcar_t       c_i;
		logic [35:0] rs;
		logic [35:0] tr;

		if (k == 0) begin : g_first
			assign v_i    = mid_valid;
			assign x_i    = mid_item.sumsq;
			assign rem_i  = '0;
			assign root_i = '0;
			assign c_i    = {mid_item.miss, mid_item.radius, mid_item.del, mid_item.rot,
				mid_item.contact};
		end else begin : g_next
			assign v_i    = sq_v[k-1];
			assign x_i    = sq_x[k-1];
			assign rem_i  = sq_rem[k-1];
			assign root_i = sq_root[k-1];
			assign c_i    = sq_c[k-1];
		end

		assign rs = {rem_i, x_i[63:62]};
		assign tr = {2'b00, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k] <= 1'b0;
			else if (en) sq_v[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_x[k] <= {x_i[61:0], 2'b00};
				sq_c[k] <= c_i;
				if (rs >= tr) begin
					sq_rem[k]  <= 34'(rs - tr);
					sq_root[k] <= {root_i[30:0], 1'b1};
				end else begin
					sq_rem[k]  <= rs[33:0];
					sq_root[k] <= {root_i[30:0], 1'b0};
				end
			end
		end
	end

	// Division setup: rounded numerators
	logic [31:0] sdist;
	logic [31:0] mag [3];
	logic        dp_v;
	logic [45:0] dp_num [3];
	logic [2:0]  dp_neg;
	logic [31:0] dp_dist;
	bcar_t       dp_c;

	assign sdist = sq_root[SQRT_STEPS-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = sq_c[SQRT_STEPS-1].del[i][31] ? (~sq_c[SQRT_STEPS-1].del[i] + 32'd1)
				: sq_c[SQRT_STEPS-1].del[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dp_v <= 1'b0;
		else if (en) dp_v <= sq_v[SQRT_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_num[i] <= {1'b0, mag[i][30:0], {UNIT_FRAC{1'b0}}} + {15'b0, sdist[31:1]};
				dp_neg[i] <= sq_c[SQRT_STEPS-1].del[i][31];
			end
			dp_dist <= sdist;
			dp_c    <= sq_c[SQRT_STEPS-1];
		end
	end

	// Normal division, one quotient bit per stage, three lanes
	logic [DIV_STEPS-1:0] dv_v;
	logic [45:0]          dv_rem  [DIV_STEPS][3];
	logic [14:0]          dv_q    [DIV_STEPS][3];
	logic [2:0]           dv_neg  [DIV_STEPS];
	logic [31:0]          dv_dist [DIV_STEPS];
	bcar_t                dv_c    [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
		logic        v_i;
		logic [45:0] rem_i [3];
		logic [14:0] q_i   [3];
		logic [2:0]  neg_i;
		logic [31:0] dist_i;
		bcar_t       c_i;
		logic [45:0] dsh;

		if (j == 0) begin : g_first
			assign v_i    = dp_v;
			assign rem_i  = dp_num;
			assign q_i    = '{default: '0};
			assign neg_i  = dp_neg;
			assign dist_i = dp_dist;
			assign c_i    = dp_c;
		end else begin : g_next
			assign v_i    = dv_v[j-1];
			assign rem_i  = dv_rem[j-1];
			assign q_i    = dv_q[j-1];
			assign neg_i  = dv_neg[j-1];
			assign dist_i = dv_dist[j-1];
			assign c_i    = dv_c[j-1];
		end

		assign dsh = 46'(dist_i) << (DIV_STEPS - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j] <= 1'b0;
			else if (en) dv_v[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_i[i] >= dsh) begin
						dv_rem[j][i] <= rem_i[i] - dsh;
						dv_q[j][i]   <= {q_i[i][13:0], 1'b1};
					end else begin
						dv_rem[j][i] <= rem_i[i];
						dv_q[j][i]   <= {q_i[i][13:0], 1'b0};
					end
				end
				dv_neg[j]  <= neg_i;
				dv_dist[j] <= dist_i;
				dv_c[j]    <= c_i;
			end
		end
	end

	// Local normal, with the fallback for a tiny distance
	logic [14:0]        qc [3];
	logic signed [15:0] nl [3];
	logic               nl_v;
	logic signed [15:0] nl_s [3];
	logic [31:0]        nl_dist;
	bcar_t              nl_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (dv_q[DIV_STEPS-1][i] > 15'(NRM_ONE)) ? 15'(NRM_ONE) : dv_q[DIV_STEPS-1][i];
			nl[i] = dv_neg[DIV_STEPS-1][i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
		end
		if (dv_dist[DIV_STEPS-1] <= 32'(NORMAL_MIN_DIST)) begin
			nl[0] = '0;
			nl[1] = 16'(NRM_ONE);
			nl[2] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nl_v <= 1'b0;
		else if (en) nl_v <= dv_v[DIV_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s    <= nl;
			nl_dist <= dv_dist[DIV_STEPS-1];
			nl_c    <= dv_c[DIV_STEPS-1];
		end
	end

	// World normal products
	logic               pr_v;
	logic signed [35:0] pr_pn [3][3];
	logic [31:0]        pr_dist;
	bcar_t              pr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pr_v <= 1'b0;
		else if (en) pr_v <= nl_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_pn[i][j] <= $signed(nl_c.rot[i][j]) * nl_s[j];
				end
			end
			pr_dist <= nl_dist;
			pr_c    <= nl_c;
		end
	end

	// Round, saturate and register the result
	logic [37:0]        an [3];
	logic signed [23:0] nr [3];
	soc_res_t           res;

	always_comb begin
		res.hit         = 1'b1;
		res.penetration = pr_c.radius - pr_dist[LEN_W-1:0];
		res.contact     = pr_c.contact;
		for (int i = 0; i < 3; i++) begin
			an[i] = {{2{pr_pn[i][0][35]}}, pr_pn[i][0]} + {{2{pr_pn[i][1][35]}}, pr_pn[i][1]}
				+ {{2{pr_pn[i][2][35]}}, pr_pn[i][2]} + 38'(RND);
			nr[i] = an[i][37:UNIT_FRAC];
			if (nr[i] > NMAX)      res.normal[i] = NMAX[QF_W-1:0];
			else if (nr[i] < NMIN) res.normal[i] = NMIN[QF_W-1:0];
			else                   res.normal[i] = nr[i][QF_W-1:0];
		end
		if (pr_c.miss) res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (en) ov_q <= pr_v;
	end

	always_ff @(posedge clk) begin
		if (en) res_q <= res;
	end

endmodule

FILE: hw/rtl/sphere_oriented_box_contact_top.sv
// Sphere against oriented box contact test.
// Input stream (s_axis_*): one sphere/box pair per item, fields packed in
// s_axis_tdata. Output stream (m_axis_*): one result per item, in order;
// m_axis_tuser carries the hit flag, m_axis_tdata penetration, world normal
// and world contact point. A miss returns an all-zero result.
// Throughput: one item per cycle while no stall holds the flow. Every unit is
// fully pipelined: the quaternion and matrix math, the 32-stage square root
// and the 15-stage normal divider each take one item per cycle unless held.
// Path: an item accepted at the input loads s1, then passes 8 more front
// stages, one queue write and 51 back stages before output valid.
// A four-entry queue sits between the front (transform, clamp, hit test,
// contact) and the back (distance, normal). When m_axis_tready is low the
// back holds, the queue fills, then the front holds and s_axis_tready falls.
// The output register holds its result stable until taken.
// Reset (arst_n low) empties all stages and the queue; no item is in flight
// afterwards and the block accepts at once.
`timescale 1ns / 1ps

module sphere_oriented_box_contact_top import soc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
	// box_size_x, box_size_y, box_size_z, box_orientation, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// penetration, normal_x, normal_y, normal_z, contact_x, contact_y,
	// contact_z, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// hit
	output logic                   m_axis_tuser
);

	logic     mid_push, mid_full, mid_pop, mid_empty;
	soc_mid_t mid_in, mid_head;
	soc_res_t res;

	soc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.mid_push (mid_push),
		.mid_item (mid_in),
		.mid_full (mid_full)
	);

	soc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mid_push),
		.push_item (mid_in),
		.full      (mid_full),
		.pop       (mid_pop),
		.empty     (mid_empty),
		.head      (mid_head)
	);

	soc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (!mid_empty),
		.mid_item  (mid_head),
		.mid_pop   (mid_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// Output packing
	assign m_axis_tuser = res.hit;
	assign m_axis_tdata = {1'b0, res.contact[2], res.contact[1], res.contact[0],
		res.normal[2], res.normal[1], res.normal[0], res.penetration};

endmodule
